// ===== design/skt_pkg.sv =====
package skt_pkg;

  // Table size and derived widths.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned ENTRY_W = KEY_W + PAY_W;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]              operation;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0]        entry_payload;
    logic [COUNT_W-1:0]      entry_count;
    logic                    last;
  } out_word_t;

endpackage

// ===== design/skt_ram.sv =====
module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sorted_key_table_insert_delete_unit.sv =====
// Sorted key table: holds up to DEPTH entries (signed key, 32-bit payload) in
// ascending key order in one single-port-read RAM, and handles one word at a
// time, taking a new one only while in_stall_o is low. An insert scans from
// the front for the first key not below the new one, then moves the tail up
// one slot. A delete scans the same way and moves the tail down. A dump reads
// the entries in order and gives one result word for each. Every step goes
// through the RAM's one registered read port. A full-table insert and an
// empty-table delete or dump each give one status word; a delete of a missing
// key stops at the first larger key or at the end of the table. Operation code
// three is dropped without a result. Output stalls hold the unit in its output
// states.
module sorted_key_table_insert_delete_unit
  import skt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_INS_RD   = 4'd3;
  localparam logic [3:0] S_INS_WR   = 4'd4;
  localparam logic [3:0] S_INS_PUT  = 4'd5;
  localparam logic [3:0] S_DEL_RD   = 4'd6;
  localparam logic [3:0] S_DEL_WR   = 4'd7;
  localparam logic [3:0] S_DUMP_RD  = 4'd8;
  localparam logic [3:0] S_DUMP_OUT = 4'd9;
  localparam logic [3:0] S_RESP     = 4'd10;

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic [1:0]              op_q, op_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0]        pay_q, pay_d;
  logic [1:0]              status_q, status_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  logic signed [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0]        rd_pay;

  logic [CNT_W-1:0]        idx_inc, idx_dec, fill_last;
  logic                    out_free;

  assign idx_inc   = idx_q + CNT_W'(1);
  assign idx_dec   = idx_q - CNT_W'(1);
  assign fill_last = fill_q - CNT_W'(1);
  assign rd_key    = $signed(ram_rdata[ENTRY_W-1:PAY_W]);
  assign rd_pay    = ram_rdata[PAY_W-1:0];

  // The output register can take a new word this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Entry storage.
  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and datapath control.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    op_d        = op_q;
    key_d       = key_q;
    pay_d       = pay_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = idx_q[ADDR_W-1:0];
    ram_raddr   = idx_q[ADDR_W-1:0];
    ram_wdata   = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = in_word_i.operation;
          key_d = in_word_i.key;
          pay_d = in_word_i.payload;
          idx_d = '0;
          case (in_word_i.operation)
            OP_INSERT: begin
              if (fill_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            OP_DELETE: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            OP_DUMP: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                state_d = S_DUMP_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Walk the entries until a key not below the operation key turns up.
      S_SCAN_RD: begin
        if (idx_q == fill_q) begin
          if (op_q == OP_INSERT) begin
            pos_d   = idx_q;
            state_d = S_INS_RD;
          end else begin
            status_d = ST_NOTFOUND;
            state_d  = S_RESP;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (rd_key < key_q) begin
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end else if (op_q == OP_INSERT) begin
          pos_d   = idx_q;
          idx_d   = fill_q;
          state_d = S_INS_RD;
        end else if (rd_key == key_q) begin
          state_d = S_DEL_RD;
        end else begin
          status_d = ST_NOTFOUND;
          state_d  = S_RESP;
        end
      end

      // Move entries up one slot, from the end down to the insert point.
      S_INS_RD: begin
        if (idx_q == pos_q) begin
          state_d = S_INS_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[ADDR_W-1:0];
          state_d   = S_INS_WR;
        end
      end

      S_INS_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_dec;
        state_d = S_INS_RD;
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[ADDR_W-1:0];
        ram_wdata = {key_q, pay_q};
        fill_d    = fill_q + CNT_W'(1);
        status_d  = ST_OK;
        state_d   = S_RESP;
      end

      // Move entries down one slot over the deleted one.
      S_DEL_RD: begin
        if (idx_q == fill_last) begin
          fill_d   = fill_last;
          status_d = ST_OK;
          state_d  = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[ADDR_W-1:0];
          state_d   = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = S_DEL_RD;
      end

      // Read each entry and hand it to the output register.
      S_DUMP_RD: begin
        ram_re  = 1'b1;
        state_d = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_word_d.status          = ST_OK;
          out_word_d.entry_key       = rd_key;
          out_word_d.entry_payload   = rd_pay;
          out_word_d.entry_count     = COUNT_W'(fill_q);
          out_word_d.last            = (idx_q == fill_last);
          if (idx_q == fill_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_DUMP_RD;
          end
        end
      end

      // Single status word for insert, delete and the empty or full cases.
      S_RESP: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_word_d.status        = status_q;
          out_word_d.entry_key     = key_q;
          out_word_d.entry_payload = '0;
          out_word_d.entry_count   = COUNT_W'(fill_q);
          out_word_d.last          = 1'b1;
          state_d                  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    op_q       <= op_d;
    key_q      <= key_d;
    pay_q      <= pay_d;
    status_q   <= status_d;
    out_word_q <= out_word_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
